// File: hw/rtl/binary_to_decimal_digits_macros.svh
// Assertion macros shared by the binary to decimal digit converter RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef BINARY_TO_DECIMAL_DIGITS_MACROS_SVH
`define BINARY_TO_DECIMAL_DIGITS_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define B2D_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define B2D_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/b2d_pkg.sv
// Package for the binary to decimal digit converter: constants, types, helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package b2d_pkg;

	localparam int VALUE_WIDTH_DEF = 64;
	localparam int BUFFER_LEN_DEF  = 24;
	localparam int VALUE_BITS      = 64;
	localparam int CHAR_W          = 6;
	localparam int INDEX_W         = 5;
	localparam int ASCII_ZERO      = 48;
	localparam int RADIX           = 10;
	localparam int BCD_THRESH      = RADIX / 2;
	localparam int BCD_ADJUST      = (16 - RADIX) / 2;
	localparam int QDEPTH          = 2;

	// decimal digits needed for the largest w-bit value (log10(2) ~ 0.30103)
	function automatic int num_digits(input int w);
		return (w * 30103) / 100000 + 1;
	endfunction

	typedef enum logic [1:0] {
		F_IDLE,
		F_CONV,
		F_HOLD
	} front_state_t;

	typedef enum logic {
		B_IDLE,
		B_RUN
	} back_state_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/b2d_front.sv
// Front end: takes a command and runs the shift-add-3 conversion into packed BCD.
// Depends on b2d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b2d_front #(
	parameter int VALUE_WIDTH = b2d_pkg::VALUE_WIDTH_DEF,
	parameter int NDIG        = b2d_pkg::num_digits(b2d_pkg::VALUE_WIDTH_DEF)
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               start,
	input  wire  [b2d_pkg::VALUE_BITS-1:0]    value,
	output logic                              busy,
	input  b2d_pkg::q_stat_t                  q_stat,
	output logic                              push,
	output logic [4*NDIG-1:0]                 bcd
);

	localparam int CNT_W = $clog2(VALUE_WIDTH);

	b2d_pkg::front_state_t state_q, state_d;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [4*NDIG-1:0]      bcd_q;
	logic [4*NDIG-1:0]      bcd_adj;
	logic [4*NDIG-1:0]      bcd_shift;
	logic [CNT_W-1:0]       cnt_q;
	logic                   take;
	logic                   conv_last;

	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[4*i +: 4] >= 4'(b2d_pkg::BCD_THRESH)) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'(b2d_pkg::BCD_ADJUST);
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	assign bcd_shift = {bcd_adj[4*NDIG-2:0], val_q[VALUE_WIDTH-1]};
	assign take      = start && !busy;
	assign conv_last = (cnt_q == CNT_W'(VALUE_WIDTH - 1));
	assign bcd       = bcd_q;

	always_comb begin
		state_d = state_q;
		busy    = (state_q != b2d_pkg::F_IDLE);
		push    = 1'b0;
		unique case (state_q)
			b2d_pkg::F_IDLE: begin
				if (start) state_d = b2d_pkg::F_CONV;
			end
			b2d_pkg::F_CONV: begin
				if (conv_last) state_d = b2d_pkg::F_HOLD;
			end
			b2d_pkg::F_HOLD: begin
				// result waits here until the queue has room
				push = !q_stat.full;
				if (!q_stat.full) state_d = b2d_pkg::F_IDLE;
			end
			default: state_d = b2d_pkg::F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= b2d_pkg::F_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (take) begin
				cnt_q <= '0;
			end else if (state_q == b2d_pkg::F_CONV) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			val_q <= value[VALUE_WIDTH-1:0];
			bcd_q <= '0;
		end else if (state_q == b2d_pkg::F_CONV) begin
			val_q <= val_q << 1;
			bcd_q <= bcd_shift;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/b2d_queue.sv
// Short queue of converted BCD words between front and back ends.
// Depends on b2d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b2d_queue #(
	parameter int WIDTH = 4 * b2d_pkg::num_digits(b2d_pkg::VALUE_WIDTH_DEF)
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	input  wire  [WIDTH-1:0]   wdata,
	input  wire                pop,
	output logic [WIDTH-1:0]   rdata,
	output b2d_pkg::q_stat_t   q_stat
);

	localparam int PTR_W = $clog2(b2d_pkg::QDEPTH);
	localparam int CNT_W = $clog2(b2d_pkg::QDEPTH + 1);

	logic [WIDTH-1:0] mem_q [b2d_pkg::QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(b2d_pkg::QDEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign rdata        = mem_q[rd_ptr_q];
	assign q_stat.empty = (cnt_q == '0);
	assign q_stat.full  = (cnt_q == CNT_W'(b2d_pkg::QDEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wdata;
	end

endmodule

`default_nettype wire

// File: hw/rtl/b2d_back.sv
// Back end: walks a BCD word from the top digit, drops leading zeros, emits ASCII.
// Depends on b2d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b2d_back #(
	parameter int NDIG  = b2d_pkg::num_digits(b2d_pkg::VALUE_WIDTH_DEF),
	parameter int LIMIT = b2d_pkg::BUFFER_LEN_DEF - 1
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  b2d_pkg::q_stat_t                  q_stat,
	input  wire  [4*NDIG-1:0]                 rdata,
	output logic                              pop,
	output logic                              digit_valid,
	output logic [b2d_pkg::CHAR_W-1:0]        digit_char,
	output logic [b2d_pkg::INDEX_W-1:0]       digit_index,
	output logic                              last
);

	localparam int POS_W = (NDIG > 1) ? $clog2(NDIG) : 1;

	b2d_pkg::back_state_t state_q, state_d;
	logic [4*NDIG-1:0]               sr_q;
	logic [POS_W-1:0]                pos_q;
	logic [b2d_pkg::INDEX_W-1:0]     idx_q;
	logic                            started_q;
	logic                            valid_q;
	logic [b2d_pkg::CHAR_W-1:0]      char_q;
	logic [b2d_pkg::INDEX_W-1:0]     index_q;
	logic                            last_q;
	logic [3:0]                      top;
	logic                            skip;
	logic                            emit;
	logic                            is_last;

	assign top     = sr_q[4*NDIG-1 -: 4];
	// leading zero, but the units digit is never skipped
	assign skip    = !started_q && (top == 4'd0) && (pos_q != '0);
	assign is_last = (pos_q == '0) || (idx_q == b2d_pkg::INDEX_W'(LIMIT - 1));

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		emit    = 1'b0;
		unique case (state_q)
			b2d_pkg::B_IDLE: begin
				pop = !q_stat.empty;
				if (!q_stat.empty) state_d = b2d_pkg::B_RUN;
			end
			b2d_pkg::B_RUN: begin
				emit = !skip;
				if (!skip && is_last) state_d = b2d_pkg::B_IDLE;
			end
			default: state_d = b2d_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= b2d_pkg::B_IDLE;
			pos_q     <= '0;
			idx_q     <= '0;
			started_q <= 1'b0;
			valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			valid_q <= emit;
			if (pop) begin
				pos_q     <= POS_W'(NDIG - 1);
				idx_q     <= '0;
				started_q <= 1'b0;
			end else if (state_q == b2d_pkg::B_RUN) begin
				pos_q <= pos_q - POS_W'(1);
				if (emit) begin
					started_q <= 1'b1;
					idx_q     <= idx_q + b2d_pkg::INDEX_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			sr_q <= rdata;
		end else if (state_q == b2d_pkg::B_RUN) begin
			sr_q <= sr_q << 4;
		end
		if (emit) begin
			char_q  <= b2d_pkg::CHAR_W'(b2d_pkg::ASCII_ZERO) + b2d_pkg::CHAR_W'(top);
			index_q <= idx_q;
			last_q  <= is_last;
		end
	end

	assign digit_valid = valid_q;
	assign digit_char  = char_q;
	assign digit_index = index_q;
	assign last        = last_q;

endmodule

`default_nettype wire

// File: hw/rtl/binary_to_decimal_digits.sv
// Top level of the binary to decimal digit converter: front end, queue, back end.
// Depends on b2d_pkg, b2d_front, b2d_queue, b2d_back and the assertion macros.
//
//   channel   handshake               payload
//   --------  ----------------------  --------------------------------
//   command   start / busy            value[63:0]
//   digits    digit_valid (strobe)    digit_char, digit_index, last
//
// The front end takes a command when start is high and busy is low, then runs
// one shift-add-3 step per value bit and hands the BCD word to the queue once
// the queue has room. The back end loads a word from the queue, then walks its
// decimal digit positions from the top (leading zeros included); the two ends
// overlap through the queue.
// Reset clears all control state; the digit stream cannot be stalled, busy
// is high while the front end converts or hands its word to the queue.
`timescale 1ns / 1ps
`default_nettype none
`include "binary_to_decimal_digits_macros.svh"

module binary_to_decimal_digits #(
	parameter int VALUE_WIDTH = b2d_pkg::VALUE_WIDTH_DEF,
	parameter int BUFFER_LEN  = b2d_pkg::BUFFER_LEN_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               start,
	input  wire  [b2d_pkg::VALUE_BITS-1:0]    value,
	output logic                              busy,
	output logic                              digit_valid,
	output logic [b2d_pkg::CHAR_W-1:0]        digit_char,
	output logic [b2d_pkg::INDEX_W-1:0]       digit_index,
	output logic                              last
);

	localparam int NDIG  = b2d_pkg::num_digits(VALUE_WIDTH);
	localparam int LIMIT = (BUFFER_LEN - 1 < NDIG) ? BUFFER_LEN - 1 : NDIG;

	logic              q_push;
	logic              q_pop;
	logic [4*NDIG-1:0] q_wdata;
	logic [4*NDIG-1:0] q_rdata;
	b2d_pkg::q_stat_t  q_stat;

	b2d_front #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.NDIG(NDIG)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.value(value),
		.busy(busy),
		.q_stat(q_stat),
		.push(q_push),
		.bcd(q_wdata)
	);

	b2d_queue #(
		.WIDTH(4 * NDIG)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.wdata(q_wdata),
		.pop(q_pop),
		.rdata(q_rdata),
		.q_stat(q_stat)
	);

	b2d_back #(
		.NDIG(NDIG),
		.LIMIT(LIMIT)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_stat(q_stat),
		.rdata(q_rdata),
		.pop(q_pop),
		.digit_valid(digit_valid),
		.digit_char(digit_char),
		.digit_index(digit_index),
		.last(last)
	);

	`B2D_ASSERT_IMP(a_no_push_full, clk, arst_n, q_push, !q_stat.full, "push into full queue")
	`B2D_ASSERT_IMP(a_no_pop_empty, clk, arst_n, q_pop, !q_stat.empty, "pop from empty queue")
	`B2D_ASSERT_NXT(a_digits_run, clk, arst_n, digit_valid && !last,
		digit_valid && (digit_index == $past(digit_index) + 5'd1), "digit run broken")
	`B2D_ASSERT_IMP(a_first_digit, clk, arst_n, digit_valid && (digit_index == 5'd0) && !last,
		digit_char != 6'(b2d_pkg::ASCII_ZERO), "leading zero emitted")

endmodule

`default_nettype wire
